### sv/prg_pkg.sv
// Shared types and constants for the priority graph reachability block.
// No dependencies; every other file depends on this package.
package prg_pkg;

	localparam int NODES   = 64;
	localparam int NODE_W  = 6;
	localparam int ROWS    = 2 ** NODE_W;
	localparam int ROW_W   = 64;
	localparam int OP_W    = 3;
	localparam int COUNT_W = 7;

	// Columns that name real nodes
	localparam logic [ROW_W-1:0] NODE_MASK = (NODES >= ROW_W) ? {ROW_W{1'b1}} :
		((ROW_W'(1) << NODES) - ROW_W'(1));

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_TEST   = 3'd2,
		OP_REACH  = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	// Request toward the adjacency row store: read, write and clear
	typedef struct packed {
		logic              rd_en;
		logic [NODE_W-1:0] rd_addr;
		logic              wr_en;
		logic [NODE_W-1:0] wr_addr;
		logic [ROW_W-1:0]  wr_data;
		logic              clr;
	} mem_req_t;

	function automatic logic node_ok(input logic [NODE_W-1:0] n);
		return int'(n) < NODES;
	endfunction

endpackage

### sv/prg_ifs.sv
// Request and response channel interfaces of the reachability block.
// Depends on prg_pkg for field widths.
interface prg_req_if;
	logic                        valid;
	logic                        ready;
	logic [prg_pkg::OP_W-1:0]    operation;
	logic [prg_pkg::NODE_W-1:0]  from_node;
	logic [prg_pkg::NODE_W-1:0]  to_node;

	modport source (output valid, output operation, output from_node, output to_node,
		input ready);
	modport sink (input valid, input operation, input from_node, input to_node,
		output ready);
endinterface

interface prg_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        path_exists;
	logic [prg_pkg::ROW_W-1:0]   reachable_mask;
	logic [prg_pkg::COUNT_W-1:0] reachable_count;

	modport source (output valid, output path_exists, output reachable_mask,
		output reachable_count, input ready);
	modport sink (input valid, input path_exists, input reachable_mask,
		input reachable_count, output ready);
endinterface

### sv/prg_row_store.sv
// Adjacency row store: one synchronous memory of rows plus per-row live bits.
// Depends on prg_pkg (mem_req_t, widths).
module prg_row_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  prg_pkg::mem_req_t         mreq,
	output logic [prg_pkg::ROW_W-1:0] rd_data
);
	import prg_pkg::*;

	logic [ROW_W-1:0] mem [ROWS];
	logic [ROW_W-1:0] data_q;
	logic [ROWS-1:0]  row_live_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.wr_addr] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			data_q <= mem[mreq.rd_addr];
		end
	end

	// A row never written since reset or clear reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_live_q <= '0;
			hit_q      <= 1'b0;
		end else begin
			if (mreq.rd_en) begin
				hit_q <= row_live_q[mreq.rd_addr];
			end
			if (mreq.clr) begin
				row_live_q <= '0;
			end else if (mreq.wr_en) begin
				row_live_q[mreq.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

### sv/priority_graph_reachability.sv
// Priority graph reachability block: a directed graph over NODES nodes kept as an
// adjacency bit matrix in one synchronous memory, one 64-bit row per source node,
// empty after reset. Each request is one operation: add edge, remove edge, test
// path, reachable set, or clear all; every request returns exactly one response,
// with fields that do not apply to the operation held at zero. Requests are taken
// one at a time. Add and remove are a read-modify-write of one row: the row is read
// as the request is taken, written back in ST_RMW and answered from ST_FIN. Clear
// drops the per-row live bits at once. Test path and reachable set walk the rows:
// the root row is read, then one pending node is popped and its row read each
// cycle until nothing is pending, as the row memory has a single read port. A node
// counts as reachable from itself only when it sits on a cycle. A node number of
// NODES or more names no node: edits with it change nothing and queries from it
// report nothing. A finished response waits in an output register while the next
// request is accepted.
// Depends on prg_pkg, prg_ifs.sv and prg_row_store.
module priority_graph_reachability (
	input logic       clk,
	input logic       arst_n,
	prg_req_if.sink   req,
	prg_rsp_if.source rsp
);
	import prg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RMW  = 4'b0010,
		ST_WALK = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	// Latched request
	logic [OP_W-1:0]   op_q;
	logic [NODE_W-1:0] from_q;
	logic [NODE_W-1:0] to_q;

	// Walk state
	logic [ROW_W-1:0]   reach_q;
	logic [ROW_W-1:0]   pending_q;
	logic [COUNT_W-1:0] count_q;

	// Finished result, then the output register
	logic               res_exists_q;
	logic [ROW_W-1:0]   res_mask_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               rsp_valid_q;
	logic               out_exists_q;
	logic [ROW_W-1:0]   out_mask_q;
	logic [COUNT_W-1:0] out_count_q;

	mem_req_t         mreq;
	logic [ROW_W-1:0] row_data;

	logic             req_fire;
	logic             fin_go;
	logic [ROW_W-1:0] fresh;
	logic [ROW_W-1:0] reach_d;
	logic [ROW_W-1:0] pend_all;
	logic [NODE_W-1:0] pick;
	logic             walk_more;
	logic [ROW_W-1:0] to_bit;

	function automatic logic [NODE_W-1:0] lowest_set(input logic [ROW_W-1:0] v);
		logic [NODE_W-1:0] idx;
		idx = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = NODE_W'(i);
			end
		end
		return idx;
	endfunction

	prg_row_store u_rows (
		.clk     (clk),
		.arst_n  (arst_n),
		.mreq    (mreq),
		.rd_data (row_data)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	// Leave the final state once the output register is free or being emptied
	assign fin_go    = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

	// Every walk cycle consumes the row read in the cycle before
	assign fresh     = row_data & NODE_MASK & ~reach_q;
	assign reach_d   = reach_q | fresh;
	assign pend_all  = pending_q | fresh;
	assign pick      = lowest_set(pend_all);
	assign walk_more = |pend_all;
	assign to_bit    = ROW_W'(1) << to_q;

	// Row store traffic
	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (req.operation)
						OP_ADD, OP_REMOVE: begin
							mreq.rd_en   = node_ok(req.from_node) && node_ok(req.to_node);
							mreq.rd_addr = req.from_node;
						end
						OP_TEST, OP_REACH: begin
							mreq.rd_en   = node_ok(req.from_node);
							mreq.rd_addr = req.from_node;
						end
						OP_CLEAR: begin
							mreq.clr = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RMW: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = from_q;
				mreq.wr_data = (op_q == OP_ADD) ? (row_data | to_bit) : (row_data & ~to_bit);
			end
			ST_WALK: begin
				mreq.rd_en   = walk_more;
				mreq.rd_addr = pick;
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if ((req.operation == OP_ADD || req.operation == OP_REMOVE) &&
							node_ok(req.from_node) && node_ok(req.to_node)) begin
							state_q <= ST_RMW;
						end else if ((req.operation == OP_TEST ||
							req.operation == OP_REACH) && node_ok(req.from_node)) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_RMW: begin
					state_q <= ST_FIN;
				end
				ST_WALK: begin
					if (!walk_more) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request latch, walk registers and result
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q         <= req.operation;
			from_q       <= req.from_node;
			to_q         <= req.to_node;
			reach_q      <= '0;
			pending_q    <= '0;
			count_q      <= '0;
			res_exists_q <= 1'b0;
			res_mask_q   <= '0;
			res_count_q  <= '0;
		end
		if (state_q == ST_WALK) begin
			if (walk_more) begin
				// Pop one pending node; each node is popped once, so pops count the set
				reach_q   <= reach_d;
				pending_q <= pend_all & ~(ROW_W'(1) << pick);
				count_q   <= count_q + COUNT_W'(1);
			end else if (op_q == OP_TEST) begin
				res_exists_q <= node_ok(to_q) && reach_d[to_q];
			end else begin
				res_mask_q  <= reach_d;
				res_count_q <= count_q;
			end
		end
		if (fin_go) begin
			out_exists_q <= res_exists_q;
			out_mask_q   <= res_mask_q;
			out_count_q  <= res_count_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.path_exists     = out_exists_q;
	assign rsp.reachable_mask  = out_mask_q;
	assign rsp.reachable_count = out_count_q;

	// The pop count must match the reported set
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && op_q == OP_REACH) |-> res_count_q == COUNT_W'($countones(res_mask_q)))
		else $error("reachable count disagrees with reachable mask");

	// Pending nodes are always already marked reachable
	a_pending_in_reach: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (pending_q & ~reach_q) == '0)
		else $error("pending node outside reachable set");

	// The row store never sees a read and a write in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.rd_en && mreq.wr_en))
		else $error("row store read and write overlap");

	// A write always follows the read of the same row issued in the cycle before
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMW) |-> $past(mreq.rd_en) && $past(mreq.rd_addr) == from_q)
		else $error("row write without its preceding read");

endmodule

### bench/testbench.sv
// Self-checking bench for the priority graph reachability block: a directed table and
// then random edit/query traffic, each response checked against a literal or bench model.
// Depends on prg_pkg, the prg_req_if / prg_rsp_if interfaces and the block's RTL.
`timescale 1ns / 100ps

module testbench;
	import prg_pkg::*;

	// Operation codes the block does not define; they must come back all zero
	localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS  = 425;
	// Keep watching after the last response to catch any response the block sends unasked
	localparam int DRAIN_CYCLES  = 2 * NODES;
	// Longest correct silence: the long receiver hold plus one full walk and a sender gap
	localparam int LONG_HOLD     = 600;
	localparam int QUIET_LIMIT   = 5000;

	localparam bit LIT  = 1'b1;	// response typed into the table
	localparam bit CALC = 1'b0;	// response taken from the graph model

	typedef struct packed {
		logic               path;
		logic [ROW_W-1:0]   mask;
		logic [COUNT_W-1:0] count;
	} graph_answer_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [NODE_W-1:0]  src;
		logic [NODE_W-1:0]  dst;
		logic               fixed;
		logic               want_path;
		logic [ROW_W-1:0]   want_mask;
		logic [COUNT_W-1:0] want_count;
	} graph_req_t;

	logic clk;
	logic arst_n;

	prg_req_if req_ch();
	prg_rsp_if rsp_ch();

	priority_graph_reachability uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	// Bench copy of the adjacency matrix: bit t of row f is the edge f -> t
	logic [ROW_W-1:0] adj_rows [ROWS];

	graph_req_t    directed_rows [DIRECTED_ROWS];
	graph_req_t    request_plan [$];
	graph_answer_t answers_due [$];
	graph_req_t    on_wire;

	int planned_total = 0;
	int requests_done = 0;
	int failures      = 0;

	// Append one request at the tail of the plan
	function automatic void plan_append(graph_req_t item);
		request_plan.insert(request_plan.size(), item);
	endfunction

	// Append one expected response at the tail of the outstanding list
	function automatic void answer_append(graph_answer_t ans);
		answers_due.insert(answers_due.size(), ans);
	endfunction

	// Nodes reachable from root over paths of one or more edges. The root only lands
	// in its own set when some walk comes back to it, i.e. it sits on a cycle.
	function automatic logic [ROW_W-1:0] reach_from(logic [NODE_W-1:0] root);
		logic [ROW_W-1:0] seen;
		logic [ROW_W-1:0] frontier;
		logic [ROW_W-1:0] fresh;
		int n;
		if (int'(root) >= NODES)
			return '0;
		seen = adj_rows[root] & NODE_MASK;
		frontier = seen;
		// Expand breadth first until a pass finds nothing new
		while (frontier != '0) begin
			fresh = '0;
			for (n = 0; n < NODES; n++)
				if (frontier[n])
					fresh |= adj_rows[n];
			fresh &= NODE_MASK & ~seen;
			seen |= fresh;
			frontier = fresh;
		end
		return seen;
	endfunction

	// Apply one request to the bench graph and return the response it must produce
	function automatic graph_answer_t apply_to_graph(logic [OP_W-1:0] op,
			logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
		graph_answer_t ans;
		logic [ROW_W-1:0] hits;
		int n;
		ans = '0;
		case (op)
		OP_ADD: begin
			if (int'(src) < NODES && int'(dst) < NODES)
				adj_rows[src][dst] = 1'b1;
		end
		OP_REMOVE: begin
			if (int'(src) < NODES && int'(dst) < NODES)
				adj_rows[src][dst] = 1'b0;
		end
		OP_TEST: begin
			if (int'(dst) < NODES) begin
				hits = reach_from(src);
				ans.path = hits[dst];
			end
		end
		OP_REACH: begin
			ans.mask = reach_from(src);
			ans.count = COUNT_W'($countones(ans.mask));
		end
		OP_CLEAR: begin
			for (n = 0; n < ROWS; n++)
				adj_rows[n] = '0;
		end
		default: ;
		endcase
		return ans;
	endfunction

	function automatic void queue_request(logic [OP_W-1:0] op, logic [NODE_W-1:0] src,
			logic [NODE_W-1:0] dst);
		graph_req_t item;
		item = '0;
		item.op = op;
		item.src = src;
		item.dst = dst;
		item.fixed = CALC;
		plan_append(item);
	endfunction

	// Random traffic is mostly edits and queries over a small pool of nodes, so that
	// paths form and the walks go deep; the rest is raw noise and the odd clear.
	// Once, half way through, every node is put on one big cycle to get a full mask.
	task automatic plan_random_traffic();
		logic [NODE_W-1:0] pool [$];
		logic [NODE_W-1:0] base;
		int goal;
		int len;
		int k;
		int pick;
		bit ring_done;
		goal = request_plan.size() + RANDOM_ITEMS;
		ring_done = 1'b0;
		while (request_plan.size() < goal) begin
			if (pool.size() == 0) begin
				len = $urandom_range(2, 12);
				repeat (len)
					pool.insert(pool.size(), NODE_W'($urandom_range(0, ROWS - 1)));
			end
			if (!ring_done && request_plan.size() > goal / 2) begin
				ring_done = 1'b1;
				base = NODE_W'($urandom_range(0, ROWS - 1));
				for (k = 0; k < NODES; k++)
					queue_request(OP_ADD, NODE_W'(base + k), NODE_W'(base + k + 1));
				queue_request(OP_REACH, NODE_W'($urandom), NODE_W'($urandom));
				queue_request(OP_TEST, NODE_W'($urandom), NODE_W'($urandom));
				// Break the cycle once and look again from just past the break
				queue_request(OP_REMOVE, base, NODE_W'(base + 1));
				queue_request(OP_REACH, NODE_W'(base + 1), NODE_W'($urandom));
				queue_request(OP_TEST, NODE_W'(base + 1), base);
				queue_request(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
				pool.delete();
				continue;
			end
			pick = $urandom_range(0, 19);
			if (pick < 9) begin
				// Chain along the pool, now and then a stray edge between pool nodes
				len = $urandom_range(1, pool.size() + 1);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(0, 3) == 0)
						queue_request(OP_ADD, pool[$urandom_range(0, pool.size() - 1)],
							pool[$urandom_range(0, pool.size() - 1)]);
					else
						queue_request(OP_ADD, pool[k % pool.size()],
							pool[(k + 1) % pool.size()]);
				end
			end else if (pick < 13) begin
				repeat ($urandom_range(1, 3))
					queue_request(OP_REMOVE, pool[$urandom_range(0, pool.size() - 1)],
						pool[$urandom_range(0, pool.size() - 1)]);
			end else if (pick < 16) begin
				repeat ($urandom_range(1, 3))
					queue_request(OP_W'($urandom_range(0, (1 << OP_W) - 1)),
						NODE_W'($urandom), NODE_W'($urandom));
				if (pool.size() < 16)
					pool.insert(pool.size(), NODE_W'($urandom_range(0, ROWS - 1)));
			end else if (pick == 16) begin
				queue_request(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
				pool.delete();
			end
			if (pick < 13 || pick > 16) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1) == 0)
						queue_request(OP_TEST, pool[$urandom_range(0, pool.size() - 1)],
							pool[$urandom_range(0, pool.size() - 1)]);
					else
						queue_request(OP_REACH, pool[$urandom_range(0, pool.size() - 1)],
							NODE_W'($urandom));
				end
			end
		end
	endtask

	// Sender: offer requests in bursts of random length with random gaps. A request
	// stays on the wire until it is accepted; the model is advanced at acceptance.
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		graph_answer_t predicted;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				predicted = apply_to_graph(on_wire.op, on_wire.src, on_wire.dst);
				if (on_wire.fixed)
					predicted = '{on_wire.want_path, on_wire.want_mask, on_wire.want_count};
				answer_append(predicted);
				requests_done++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (request_plan.size() > 0) begin
					on_wire = request_plan.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.operation <= on_wire.op;
					req_ch.from_node <= on_wire.src;
					req_ch.to_node <= on_wire.dst;
					if (burst_left <= 1) begin
						// New burst; a quarter of them follow on with no gap at all
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: ready follows a rotating 16-bit pattern that is redrawn when its age runs out,
	// sometimes all ones. Once, after 150 responses, hold ready low for a long stretch
	// so the output register fills and the block has to stall its request side.
	logic [15:0] stall_pattern = '1;
	int pattern_age    = 0;
	int hold_left      = 0;
	int responses_seen = 0;
	bit long_hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				responses_seen++;
			if (!long_hold_done && responses_seen >= 150) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (pattern_age == 0) begin
				pattern_age = 64;
				case ($urandom_range(0, 3))
				0: stall_pattern = '1;
				1: stall_pattern = 16'($urandom);
				2: stall_pattern = 16'($urandom) | 16'($urandom);
				default: stall_pattern = 16'($urandom) & 16'($urandom);
				endcase
			end
			pattern_age--;
			stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= stall_pattern[0];
			end
		end
	end

	// Checker: every accepted response must match the oldest outstanding prediction
	always @(posedge clk) begin
		graph_answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (answers_due.size() == 0) begin
				$error("response with no request outstanding");
				failures++;
			end else begin
				want = answers_due.pop_front();
				if (rsp_ch.path_exists !== want.path) begin
					$error("path_exists: expected %0d, got %0d", want.path, rsp_ch.path_exists);
					failures++;
				end
				if (rsp_ch.reachable_mask !== want.mask) begin
					$error("reachable_mask: expected %h, got %h", want.mask,
						rsp_ch.reachable_mask);
					failures++;
				end
				if (rsp_ch.reachable_count !== want.count) begin
					$error("reachable_count: expected %0d, got %0d", want.count,
						rsp_ch.reachable_count);
					failures++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = '0;
		req_ch.from_node = '0;
		req_ch.to_node = '0;
		rsp_ch.ready = 1'b0;
		for (n = 0; n < ROWS; n++)
			adj_rows[n] = '0;

		// Directed part. Literal rows hold what can be read straight off the graph;
		// the rest are left to the model.
		directed_rows = '{
			// empty graph after reset
			'{OP_REACH,  6'd0,  6'd0,  LIT,  1'b0, 64'd0, 7'd0},
			'{OP_TEST,   6'd63, 6'd63, LIT,  1'b0, 64'd0, 7'd0},
			// extreme nodes, with a duplicate add in between
			'{OP_ADD,    6'd0,  6'd63, LIT,  1'b0, 64'd0, 7'd0},
			'{OP_ADD,    6'd0,  6'd63, LIT,  1'b0, 64'd0, 7'd0},
			'{OP_ADD,    6'd63, 6'd0,  LIT,  1'b0, 64'd0, 7'd0},
			'{OP_REACH,  6'd0,  6'd21, LIT,  1'b0, 64'h8000_0000_0000_0001, 7'd2},
			'{OP_TEST,   6'd0,  6'd0,  LIT,  1'b1, 64'd0, 7'd0},
			'{OP_TEST,   6'd63, 6'd63, LIT,  1'b1, 64'd0, 7'd0},
			// removing an edge that is not there
			'{OP_REMOVE, 6'd21, 6'd42, LIT,  1'b0, 64'd0, 7'd0},
			// a self edge puts its node on a cycle
			'{OP_ADD,    6'd42, 6'd42, LIT,  1'b0, 64'd0, 7'd0},
			'{OP_REACH,  6'd42, 6'd0,  LIT,  1'b0, 64'h0000_0400_0000_0000, 7'd1},
			'{OP_TEST,   6'd42, 6'd42, LIT,  1'b1, 64'd0, 7'd0},
			// three-node cycle
			'{OP_ADD,    6'd1,  6'd2,  CALC, 1'b0, 64'd0, 7'd0},
			'{OP_ADD,    6'd2,  6'd3,  CALC, 1'b0, 64'd0, 7'd0},
			'{OP_ADD,    6'd3,  6'd1,  CALC, 1'b0, 64'd0, 7'd0},
			'{OP_TEST,   6'd1,  6'd3,  CALC, 1'b0, 64'd0, 7'd0},
			'{OP_REACH,  6'd2,  6'd63, CALC, 1'b0, 64'd0, 7'd0},
			'{OP_TEST,   6'd3,  6'd63, CALC, 1'b0, 64'd0, 7'd0},
			// undefined operation codes
			'{OP_RSVD_5, 6'd63, 6'd63, LIT,  1'b0, 64'd0, 7'd0},
			'{OP_RSVD_7, 6'd0,  6'd0,  LIT,  1'b0, 64'd0, 7'd0},
			'{OP_RSVD_6, 6'd21, 6'd42, LIT,  1'b0, 64'd0, 7'd0},
			// break the 0/63 cycle: 0 still reaches 63, but no longer itself
			'{OP_REMOVE, 6'd63, 6'd0,  LIT,  1'b0, 64'd0, 7'd0},
			'{OP_REACH,  6'd0,  6'd0,  LIT,  1'b0, 64'h8000_0000_0000_0000, 7'd1},
			// clear wipes everything, the self edge included
			'{OP_CLEAR,  6'd42, 6'd21, LIT,  1'b0, 64'd0, 7'd0},
			'{OP_REACH,  6'd42, 6'd42, LIT,  1'b0, 64'd0, 7'd0}
		};
		foreach (directed_rows[r])
			plan_append(directed_rows[r]);
		plan_random_traffic();
		planned_total = request_plan.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go in and every response to come back, then
		// hold a little longer to catch anything the block sends unasked
		while (requests_done < planned_total)
			@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
sv/prg_pkg.sv
sv/prg_ifs.sv
sv/prg_row_store.sv
sv/priority_graph_reachability.sv
bench/testbench.sv
